/* hdl/rgb_median_3x3_filter_assert.svh */
// ----------------------------------------------------------------------------
// rgb median 3x3 filter assertion macros
// Shorthand for the clocked assertions in the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_MEDIAN_3X3_FILTER_ASSERT_SVH
`define RGB_MEDIAN_3X3_FILTER_ASSERT_SVH

// same-cycle implication, idle while reset is active
`define RMF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle while reset is active
`define RMF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// checked only while reset is active
`define RMF_ASSERT_RST(name, cons, msg) \
  name: assert property (@(posedge clk_i) !rst_ni |-> (cons)) \
    else $error(msg);

`endif

/* hdl/rmf_pkg.sv */
// ----------------------------------------------------------------------------
// rmf_pkg
// Types, constants and compare helpers of the rgb 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

  localparam int WINDOW_SIZE  = 3;
  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHAN     = 3;
  localparam int PIXEL_BITS   = NUM_CHAN * CHANNEL_BITS;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0]   pixel_t;
  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    pixel_t lower;
    pixel_t center;
    pixel_t upper;
  } column_t;

  typedef struct packed {
    column_t left;
    column_t mid;
    column_t right;
    logic    done;
  } job_t;

  typedef struct packed {
    chan_t hi;
    chan_t md;
    chan_t lo;
  } trio_t;

  // channel 0 is red (top byte), 2 is blue (bottom byte)
  function automatic chan_t pixel_chan(pixel_t pix, int ch);
    return pix[CHANNEL_BITS*(NUM_CHAN-1-ch) +: CHANNEL_BITS];
  endfunction

  function automatic chan_t max2(chan_t a, chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t min2(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(chan_t a, chan_t b, chan_t c);
    trio_t t;
    t.lo = min2(min2(a, b), c);
    t.hi = max2(max2(a, b), c);
    t.md = med3(a, b, c);
    return t;
  endfunction

endpackage

`default_nettype wire

/* hdl/rmf_front.sv */
// ----------------------------------------------------------------------------
// rmf_front
// Keeps the last two columns, replicates row edges and builds window jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmf_pkg::column_t in_col_i,
  input  logic            in_first_i,
  input  logic            in_final_i,
  output logic            push_o,
  output rmf_pkg::job_t   push_job_o,
  input  logic            full_i
);

  logic [1:0]       held_q, held_d, held;
  rmf_pkg::column_t older_q, newer_q;
  logic             extra_v_q;
  rmf_pkg::job_t    extra_job_q;
  rmf_pkg::job_t    job_a, job_b;
  logic             has_a, accept;

  assign in_ready_o = !extra_v_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign held       = in_first_i ? 2'd0 : held_q;
  assign has_a      = (held != 2'd0);

  always_comb begin
    job_a.left  = (held == 2'd2) ? older_q : newer_q;
    job_a.mid   = newer_q;
    job_a.right = in_col_i;
    job_a.done  = 1'b0;
    job_b.left  = has_a ? newer_q : in_col_i;
    job_b.mid   = in_col_i;
    job_b.right = in_col_i;
    job_b.done  = 1'b1;
  end

  always_comb begin
    if (extra_v_q) begin
      push_o     = !full_i;
      push_job_o = extra_job_q;
    end else begin
      push_o     = accept && (has_a || in_final_i);
      push_job_o = has_a ? job_a : job_b;
    end
  end

  always_comb begin
    held_d = held_q;
    if (accept) begin
      if (in_final_i) begin
        held_d = 2'd0;
      end else begin
        held_d = (held == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= 2'd0;
      extra_v_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (extra_v_q && !full_i) begin
        extra_v_q <= 1'b0;
      end else if (accept && has_a && in_final_i) begin
        extra_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      older_q <= newer_q;
      newer_q <= in_col_i;
      if (has_a && in_final_i) begin
        extra_job_q <= job_b;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/rmf_queue.sv */
// ----------------------------------------------------------------------------
// rmf_queue
// Short job queue between the window builder and the median pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmf_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rmf_pkg::job_t pop_job_o
);

  rmf_pkg::job_t                 mem_q [rmf_pkg::QUEUE_DEPTH];
  logic [rmf_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [rmf_pkg::QUEUE_CW-1:0]  count_q;
  logic                          do_push, do_pop;

  assign full_o    = (count_q == rmf_pkg::QUEUE_CW'(rmf_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/rmf_median.sv */
// ----------------------------------------------------------------------------
// rmf_median
// Median-of-nine network per channel: column sort, merge, final median stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_median (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  rmf_pkg::job_t                     job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rmf_pkg::PIXEL_BITS-1:0]    out_data_o,
  output logic                              out_done_o
);

  rmf_pkg::column_t cols [rmf_pkg::WINDOW_SIZE];
  rmf_pkg::trio_t   s1_d [rmf_pkg::NUM_CHAN][rmf_pkg::WINDOW_SIZE];
  rmf_pkg::trio_t   s1_q [rmf_pkg::NUM_CHAN][rmf_pkg::WINDOW_SIZE];
  rmf_pkg::trio_t   s2_d [rmf_pkg::NUM_CHAN];
  rmf_pkg::trio_t   s2_q [rmf_pkg::NUM_CHAN];
  rmf_pkg::chan_t   med_d [rmf_pkg::NUM_CHAN];
  rmf_pkg::chan_t   med_q [rmf_pkg::NUM_CHAN];
  logic             s1_v_q, s2_v_q, out_v_q;
  logic             s1_done_q, s2_done_q, out_done_q;
  logic             s1_ready, s2_ready, out_ready;

  assign out_ready   = !out_v_q || out_ready_i;
  assign s2_ready    = !s2_v_q || out_ready;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign job_ready_o = s1_ready;

  assign cols[0] = job_i.left;
  assign cols[1] = job_i.mid;
  assign cols[2] = job_i.right;

  // sort each column of the window
  always_comb begin
    for (int ch = 0; ch < rmf_pkg::NUM_CHAN; ch++) begin
      for (int c = 0; c < rmf_pkg::WINDOW_SIZE; c++) begin
        s1_d[ch][c] = rmf_pkg::sort3(rmf_pkg::pixel_chan(cols[c].upper, ch),
                                     rmf_pkg::pixel_chan(cols[c].center, ch),
                                     rmf_pkg::pixel_chan(cols[c].lower, ch));
      end
    end
  end

  // max of lows, median of mids, min of highs
  always_comb begin
    for (int ch = 0; ch < rmf_pkg::NUM_CHAN; ch++) begin
      s2_d[ch].lo = rmf_pkg::max2(rmf_pkg::max2(s1_q[ch][0].lo, s1_q[ch][1].lo),
                                  s1_q[ch][2].lo);
      s2_d[ch].md = rmf_pkg::med3(s1_q[ch][0].md, s1_q[ch][1].md, s1_q[ch][2].md);
      s2_d[ch].hi = rmf_pkg::min2(rmf_pkg::min2(s1_q[ch][0].hi, s1_q[ch][1].hi),
                                  s1_q[ch][2].hi);
      med_d[ch]   = rmf_pkg::med3(s2_q[ch].lo, s2_q[ch].md, s2_q[ch].hi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= job_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_q      <= s1_d;
      s1_done_q <= job_i.done;
    end
    if (s2_ready) begin
      s2_q      <= s2_d;
      s2_done_q <= s1_done_q;
    end
    if (out_ready) begin
      med_q      <= med_d;
      out_done_q <= s2_done_q;
    end
  end

  // red in the low byte
  assign out_valid_o = out_v_q;
  assign out_data_o  = {med_q[2], med_q[1], med_q[0]};
  assign out_done_o  = out_done_q;

endmodule

`default_nettype wire

/* hdl/rgb_median_3x3_filter.sv */
// ----------------------------------------------------------------------------
// rgb_median_3x3_filter
// Column-streaming 3x3 median filter, separate medians for red, green, blue.
// ----------------------------------------------------------------------------
// Takes one three-pixel column per clock in raster order while the job
// queue is not full and no row end is pending (rows above, at and below the
// centre, top and bottom borders already replicated) and returns the
// per-channel 3x3 median of the previous column's centre pixel, with the
// left and right edges replicated. A column that ends a row (tlast) gives two
// results when columns are held, so it holds off the next column until the
// second job is written: the window builder writes one job per cycle into
// the job queue while it is not full; other columns give at most one job.
// Each job goes from the queue read into column sort, merge of the sorted
// columns and the final median stage that feeds the output register.
`default_nettype none

module rgb_median_3x3_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // lower_pixel, center_pixel, upper_pixel
  input  logic        s_axis_tuser,  // row_first
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // median_blue, median_green, median_red
  output logic        m_axis_tlast
);

  rmf_pkg::column_t in_col;
  rmf_pkg::job_t    push_job, pop_job;
  logic             push, full, q_valid, pop_ready;

  assign in_col.upper  = s_axis_tdata[rmf_pkg::PIXEL_BITS-1:0];
  assign in_col.center = s_axis_tdata[2*rmf_pkg::PIXEL_BITS-1:rmf_pkg::PIXEL_BITS];
  assign in_col.lower  = s_axis_tdata[3*rmf_pkg::PIXEL_BITS-1:2*rmf_pkg::PIXEL_BITS];

  rmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_col_i   (in_col),
    .in_first_i (s_axis_tuser),
    .in_final_i (s_axis_tlast),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  rmf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop_ready),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  rmf_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_done_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* hdl/rmf_checker.sv */
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the rgb 3x3 median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_median_3x3_filter_assert.svh"

module rmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result transaction holds
  `RMF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // no result while in reset
  `RMF_ASSERT_RST(a_rst_idle, !m_axis_tvalid, "result valid during reset")

  // input back-pressure only from a row end or a stalled output
  `RMF_ASSERT_IMP(a_ready_drop, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tlast) || $past(m_axis_tvalid && !m_axis_tready), "unexpected input stall")

  // a dropped input ready comes back while the output drains freely
  `RMF_ASSERT_NXT(a_ready_back, !s_axis_tready && $past(m_axis_tready) && m_axis_tready, s_axis_tready || !m_axis_tready, "input stall persists")

endmodule

bind rgb_median_3x3_filter rmf_checker u_rmf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
